/* hdl/pdfc_pkg.sv */
`default_nettype none

package pdfc_pkg;

	localparam int DUTY_W = 7;
	localparam int RATE_W = 27;
	localparam int FIELD_W = 16;
	localparam int DUTY_SCALE = 100;
	localparam int QUEUE_DEPTH = 4;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [RATE_W-1:0] RATE_RESET = 27'd8000000;

	// register index taken from paddr above the byte offset
	localparam logic [ADDR_W-3:0] REG_TICK_RATE = 1'b0;

	typedef logic [FIELD_W-1:0] field_t;
	typedef logic [RATE_W-1:0] rate_t;

	typedef struct packed {
		logic signal_level;
	} in_word_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty_percent;
		logic [RATE_W-1:0] frequency_hz;
		logic [FIELD_W-1:0] high_ticks;
		logic [FIELD_W-1:0] period_ticks;
		logic period_zero;
	} out_word_t;

	typedef enum logic [2:0] {
		PH_RISE1 = 3'b001,
		PH_FALL = 3'b010,
		PH_RISE2 = 3'b100
	} phase_t;

	typedef enum logic [4:0] {
		B_IDLE = 5'b00001,
		B_MUL = 5'b00010,
		B_DUTY = 5'b00100,
		B_FREQ = 5'b01000,
		B_OUT = 5'b10000
	} back_state_t;

endpackage

`default_nettype wire

/* hdl/pdfc_stream_if.sv */
`default_nettype none

interface pdfc_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

/* hdl/pwm_duty_frequency_capture.sv */
// result path: the closing rising edge pushes a measurement into the queue; the back end
// pops it, runs the bit-serial duty and frequency dividers (skipping the duty divider for a
// saturated duty and both for a zero period) and offers the result word; queued measurements wait their turn
// throughput: one sample word per cycle while the measurement queue has room; the back end
// works on one measurement at a time
// reset: arst_n clears counter, edge state, queue and back end; tick rate returns to 8000000
`default_nettype none

module pwm_duty_frequency_capture #(
	parameter int COUNTER_WIDTH = 16
) (
	input logic clk,
	input logic arst_n,
	pdfc_stream_if.sink sample,
	pdfc_stream_if.source result,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [pdfc_pkg::ADDR_W-1:0] paddr,
	input logic [pdfc_pkg::DATA_W-1:0] pwdata,
	output logic [pdfc_pkg::DATA_W-1:0] prdata,
	output logic pready
);

	pdfc_pkg::rate_t tick_rate_q;
	logic reg_sel;

	logic q_full;
	logic q_not_empty;
	logic push;
	logic pop;
	logic [COUNTER_WIDTH-1:0] push_high;
	logic [COUNTER_WIDTH-1:0] push_period;
	logic [COUNTER_WIDTH-1:0] pop_high;
	logic [COUNTER_WIDTH-1:0] pop_period;

	assign pready = 1'b1;
	assign reg_sel = (paddr[pdfc_pkg::ADDR_W-1:2] == pdfc_pkg::REG_TICK_RATE);
	assign prdata = reg_sel ? pdfc_pkg::DATA_W'(tick_rate_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_rate_q <= pdfc_pkg::RATE_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			tick_rate_q <= pwdata[pdfc_pkg::RATE_W-1:0];
		end
	end

	pdfc_front #(
		.CW(COUNTER_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample),
		.q_full(q_full),
		.push(push),
		.push_high(push_high),
		.push_period(push_period)
	);

	pdfc_queue #(
		.CW(COUNTER_WIDTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_high(push_high),
		.push_period(push_period),
		.full(q_full),
		.not_empty(q_not_empty),
		.pop(pop),
		.pop_high(pop_high),
		.pop_period(pop_period)
	);

	pdfc_back #(
		.CW(COUNTER_WIDTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_not_empty),
		.q_high(pop_high),
		.q_period(pop_period),
		.pop(pop),
		.tick_rate(tick_rate_q),
		.result(result)
	);

endmodule

`default_nettype wire

/* hdl/pdfc_front.sv */
`default_nettype none

module pdfc_front #(
	parameter int CW = 16
) (
	input logic clk,
	input logic arst_n,
	pdfc_stream_if.sink sample,
	input logic q_full,
	output logic push,
	output logic [CW-1:0] push_high,
	output logic [CW-1:0] push_period
);

	logic [CW-1:0] tick_q;
	logic [CW-1:0] first_q;
	logic [CW-1:0] fall_q;
	logic level_q;
	pdfc_pkg::phase_t phase_q;
	pdfc_pkg::phase_t phase_d;
	logic take;
	logic rise;
	logic fall;
	logic cap_first;
	logic cap_fall;

	assign sample.ready = !q_full;
	assign take = sample.valid && sample.ready;
	assign rise = sample.data.signal_level && !level_q;
	assign fall = !sample.data.signal_level && level_q;

	always_comb begin
		phase_d = phase_q;
		push = 1'b0;
		cap_first = 1'b0;
		cap_fall = 1'b0;
		unique case (phase_q)
			pdfc_pkg::PH_FALL: begin
				if (take && fall) begin
					cap_fall = 1'b1;
					phase_d = pdfc_pkg::PH_RISE2;
				end
			end
			pdfc_pkg::PH_RISE2: begin
				// closing edge only rearms, it does not open the next window
				if (take && rise) begin
					push = 1'b1;
					phase_d = pdfc_pkg::PH_RISE1;
				end
			end
			default: begin
				if (take && rise) begin
					cap_first = 1'b1;
					phase_d = pdfc_pkg::PH_FALL;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			level_q <= 1'b0;
			phase_q <= pdfc_pkg::PH_RISE1;
			first_q <= '0;
			fall_q <= '0;
		end else if (take) begin
			tick_q <= tick_q + 1'b1;
			level_q <= sample.data.signal_level;
			phase_q <= phase_d;
			if (cap_first) begin
				first_q <= tick_q;
			end
			if (cap_fall) begin
				fall_q <= tick_q;
			end
		end
	end

	assign push_high = fall_q - first_q;
	assign push_period = tick_q - first_q;

endmodule

`default_nettype wire

/* hdl/pdfc_queue.sv */
`default_nettype none

module pdfc_queue #(
	parameter int CW = 16
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [CW-1:0] push_high,
	input logic [CW-1:0] push_period,
	output logic full,
	output logic not_empty,
	input logic pop,
	output logic [CW-1:0] pop_high,
	output logic [CW-1:0] pop_period
);

	localparam int PW = $clog2(pdfc_pkg::QUEUE_DEPTH);
	localparam int NW = $clog2(pdfc_pkg::QUEUE_DEPTH + 1);

	logic [CW-1:0] high_mem_q [pdfc_pkg::QUEUE_DEPTH];
	logic [CW-1:0] period_mem_q [pdfc_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;

	assign full = (count_q == NW'(pdfc_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_high = high_mem_q[rd_ptr_q];
	assign pop_period = period_mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			high_mem_q[wr_ptr_q] <= push_high;
			period_mem_q[wr_ptr_q] <= push_period;
		end
	end

endmodule

`default_nettype wire

/* hdl/pdfc_back.sv */
`default_nettype none

module pdfc_back #(
	parameter int CW = 16
) (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	input logic [CW-1:0] q_high,
	input logic [CW-1:0] q_period,
	output logic pop,
	input pdfc_pkg::rate_t tick_rate,
	pdfc_stream_if.source result
);

	// duty numerator width: high * 100 fits in CW + 7 bits
	localparam int PW = CW + pdfc_pkg::DUTY_W;
	localparam int DW = (PW > pdfc_pkg::RATE_W) ? PW : pdfc_pkg::RATE_W;
	localparam int KW = $clog2(DW + 1);

	pdfc_pkg::back_state_t state_q;
	logic [KW-1:0] cnt_q;
	logic [CW-1:0] high_q;
	logic [CW-1:0] period_q;
	logic [DW-1:0] dvd_q;
	logic [CW-1:0] rem_q;
	logic [pdfc_pkg::RATE_W-1:0] quo_q;
	logic [pdfc_pkg::DUTY_W-1:0] duty_q;
	logic [pdfc_pkg::RATE_W-1:0] freq_q;
	logic pzero_q;

	logic [PW-1:0] prod;
	logic [DW-1:0] dvd_duty;
	logic [DW-1:0] dvd_rate;
	logic [CW:0] rem_sh;
	logic [CW:0] rem_sub;
	logic ge;
	logic [CW-1:0] rem_n;
	logic [pdfc_pkg::RATE_W-1:0] quo_n;
	logic last;

	assign prod = {{pdfc_pkg::DUTY_W{1'b0}}, high_q} * PW'(pdfc_pkg::DUTY_SCALE);
	assign dvd_duty = DW'(prod) << (DW - PW);
	assign dvd_rate = DW'(tick_rate) << (DW - pdfc_pkg::RATE_W);

	// one restoring long-division step per cycle
	assign rem_sh = {rem_q, dvd_q[DW-1]};
	assign rem_sub = rem_sh - {1'b0, period_q};
	assign ge = (rem_sh >= {1'b0, period_q});
	assign rem_n = ge ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
	assign quo_n = {quo_q[pdfc_pkg::RATE_W-2:0], ge};
	assign last = (cnt_q == KW'(1));

	assign pop = (state_q == pdfc_pkg::B_IDLE) && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pdfc_pkg::B_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				pdfc_pkg::B_IDLE: begin
					if (q_valid) begin
						state_q <= pdfc_pkg::B_MUL;
					end
				end
				pdfc_pkg::B_MUL: begin
					if (period_q == '0) begin
						state_q <= pdfc_pkg::B_OUT;
					end else if (high_q >= period_q) begin
						cnt_q <= KW'(pdfc_pkg::RATE_W);
						state_q <= pdfc_pkg::B_FREQ;
					end else begin
						cnt_q <= KW'(PW);
						state_q <= pdfc_pkg::B_DUTY;
					end
				end
				pdfc_pkg::B_DUTY: begin
					if (last) begin
						cnt_q <= KW'(pdfc_pkg::RATE_W);
						state_q <= pdfc_pkg::B_FREQ;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				pdfc_pkg::B_FREQ: begin
					if (last) begin
						state_q <= pdfc_pkg::B_OUT;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				pdfc_pkg::B_OUT: begin
					if (result.ready) begin
						state_q <= pdfc_pkg::B_IDLE;
					end
				end
				default: begin
					state_q <= pdfc_pkg::B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			pdfc_pkg::B_IDLE: begin
				if (q_valid) begin
					high_q <= q_high;
					period_q <= q_period;
				end
			end
			pdfc_pkg::B_MUL: begin
				rem_q <= '0;
				quo_q <= '0;
				if (period_q == '0) begin
					pzero_q <= 1'b1;
					duty_q <= '0;
					freq_q <= '0;
				end else if (high_q >= period_q) begin
					// quotient would reach 100 or more
					pzero_q <= 1'b0;
					duty_q <= pdfc_pkg::DUTY_W'(pdfc_pkg::DUTY_SCALE);
					dvd_q <= dvd_rate;
				end else begin
					pzero_q <= 1'b0;
					dvd_q <= dvd_duty;
				end
			end
			pdfc_pkg::B_DUTY: begin
				if (last) begin
					duty_q <= quo_n[pdfc_pkg::DUTY_W-1:0];
					rem_q <= '0;
					quo_q <= '0;
					dvd_q <= dvd_rate;
				end else begin
					rem_q <= rem_n;
					quo_q <= quo_n;
					dvd_q <= dvd_q << 1;
				end
			end
			pdfc_pkg::B_FREQ: begin
				rem_q <= rem_n;
				quo_q <= quo_n;
				dvd_q <= dvd_q << 1;
				if (last) begin
					freq_q <= quo_n;
				end
			end
			default: begin
			end
		endcase
	end

	assign result.valid = (state_q == pdfc_pkg::B_OUT);
	assign result.data.duty_percent = duty_q;
	assign result.data.frequency_hz = freq_q;
	assign result.data.high_ticks = pdfc_pkg::field_t'(high_q);
	assign result.data.period_ticks = pdfc_pkg::field_t'(period_q);
	assign result.data.period_zero = pzero_q;

endmodule

`default_nettype wire

/* bench/tb_top.sv */
`default_nettype none

module tb_top;

	localparam int unsigned RUN_LIMIT = 1000000;
	localparam int unsigned SETTLE_CYCLES = 80;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned PHASE_TICKS = 60;
	localparam int unsigned PHASE_PULSES = 6;
	localparam int unsigned SQUEEZE_PULSES = 12;
	localparam logic [pdfc_pkg::ADDR_W-3:0] REG_BEYOND = 1'b1;

	typedef struct packed {
		logic level;
		logic burst;
	} tick_t;

	logic clk;
	logic arst_n = 1'b1;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [pdfc_pkg::ADDR_W-1:0] paddr = '0;
	logic [pdfc_pkg::DATA_W-1:0] pwdata = '0;
	logic [pdfc_pkg::DATA_W-1:0] prdata;
	logic pready;

	pdfc_stream_if #(.T(pdfc_pkg::in_word_t)) sample_if ();
	pdfc_stream_if #(.T(pdfc_pkg::out_word_t)) result_if ();

	pwm_duty_frequency_capture dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample_if),
		.result(result_if),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// stimulus and expected measurements
	tick_t tick_q[$];
	pdfc_pkg::out_word_t meas_q[$];
	int unsigned miss_cnt = 0;
	int unsigned cycle_cnt = 0;
	logic squeeze_req = 1'b0;

	// capture predictor state
	pdfc_pkg::rate_t rate_q;
	pdfc_pkg::field_t tick_cnt;
	pdfc_pkg::field_t rise_stamp;
	pdfc_pkg::field_t fall_stamp;
	logic prev_lvl;
	pdfc_pkg::phase_t cap_phase;

	function automatic void reset_capture();
		rate_q = pdfc_pkg::RATE_RESET;
		tick_cnt = '0;
		rise_stamp = '0;
		fall_stamp = '0;
		prev_lvl = 1'b0;
		cap_phase = pdfc_pkg::PH_RISE1;
	endfunction

	function automatic void rate_write(input logic [pdfc_pkg::ADDR_W-3:0] idx,
			input logic [pdfc_pkg::DATA_W-1:0] val);
		if (idx == pdfc_pkg::REG_TICK_RATE)
			rate_q = val[pdfc_pkg::RATE_W-1:0];
	endfunction

	function automatic void advance_capture(input logic lvl);
		logic rise;
		logic fall;
		pdfc_pkg::field_t high_w;
		pdfc_pkg::field_t period_w;
		int unsigned duty;
		int unsigned freq;
		pdfc_pkg::out_word_t w;
		rise = lvl && !prev_lvl;
		fall = !lvl && prev_lvl;
		case (cap_phase)
			pdfc_pkg::PH_FALL: begin
				if (fall) begin
					fall_stamp = tick_cnt;
					cap_phase = pdfc_pkg::PH_RISE2;
				end
			end
			pdfc_pkg::PH_RISE2: begin
				if (rise) begin
					high_w = fall_stamp - rise_stamp;
					period_w = tick_cnt - rise_stamp;
					duty = 0;
					freq = 0;
					if (period_w != '0) begin
						duty = (int'(high_w) * pdfc_pkg::DUTY_SCALE) / int'(period_w);
						if (duty > pdfc_pkg::DUTY_SCALE)
							duty = pdfc_pkg::DUTY_SCALE;
						freq = int'(rate_q) / int'(period_w);
					end
					w.duty_percent = duty[pdfc_pkg::DUTY_W-1:0];
					w.frequency_hz = freq[pdfc_pkg::RATE_W-1:0];
					w.high_ticks = high_w;
					w.period_ticks = period_w;
					w.period_zero = (period_w == '0);
					meas_q.push_back(w);
					cap_phase = pdfc_pkg::PH_RISE1;
				end
			end
			default: begin
				if (rise) begin
					rise_stamp = tick_cnt;
					cap_phase = pdfc_pkg::PH_FALL;
				end
			end
		endcase
		prev_lvl = lvl;
		tick_cnt = tick_cnt + 1'b1;
	endfunction

	// mostly no pause, sometimes short, rarely long
	function automatic int unsigned pick_pause();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == RUN_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// sample driver
	int unsigned idle_left;
	tick_t nxt;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_if.valid <= 1'b0;
			sample_if.data <= '0;
			idle_left <= 0;
		end else begin
			if (sample_if.valid && sample_if.ready)
				advance_capture(sample_if.data.signal_level);
			if (!sample_if.valid || sample_if.ready) begin
				if (idle_left != 0) begin
					sample_if.valid <= 1'b0;
					idle_left <= idle_left - 1;
				end else if (tick_q.size() != 0) begin
					nxt = tick_q.pop_front();
					sample_if.valid <= 1'b1;
					sample_if.data <= pdfc_pkg::in_word_t'(nxt.level);
					idle_left <= nxt.burst ? 0 : pick_pause();
				end else begin
					sample_if.valid <= 1'b0;
				end
			end
		end
	end

	// result ready, with one long hold-off on request
	int unsigned stall_left;
	int unsigned pause_len;
	logic squeeze_done;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
			stall_left <= 0;
			squeeze_done <= 1'b0;
		end else if (squeeze_req && !squeeze_done) begin
			squeeze_done <= 1'b1;
			stall_left <= HOLD_CYCLES;
			result_if.ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			result_if.ready <= 1'b0;
		end else begin
			pause_len = pick_pause();
			result_if.ready <= (pause_len == 0);
			stall_left <= (pause_len == 0) ? 0 : pause_len - 1;
		end
	end

	// result checker
	pdfc_pkg::out_word_t want;

	always @(posedge clk) begin
		if (arst_n && result_if.valid && result_if.ready) begin
			if (meas_q.size() == 0) begin
				miss_cnt = miss_cnt + 1;
				if (miss_cnt <= 10)
					$display("unexpected word: duty %0d freq %0d high %0d period %0d zero %0d",
						result_if.data.duty_percent, result_if.data.frequency_hz,
						result_if.data.high_ticks, result_if.data.period_ticks,
						result_if.data.period_zero);
			end else begin
				want = meas_q.pop_front();
				if (result_if.data.duty_percent !== want.duty_percent ||
						result_if.data.frequency_hz !== want.frequency_hz ||
						result_if.data.high_ticks !== want.high_ticks ||
						result_if.data.period_ticks !== want.period_ticks ||
						result_if.data.period_zero !== want.period_zero) begin
					miss_cnt = miss_cnt + 1;
					if (miss_cnt <= 10) begin
						$display("mismatch: exp duty %0d freq %0d high %0d period %0d zero %0d",
							want.duty_percent, want.frequency_hz, want.high_ticks,
							want.period_ticks, want.period_zero);
						$display("          got duty %0d freq %0d high %0d period %0d zero %0d",
							result_if.data.duty_percent, result_if.data.frequency_hz,
							result_if.data.high_ticks, result_if.data.period_ticks,
							result_if.data.period_zero);
					end
				end
			end
		end
	end

	task automatic add_run(input logic lvl, input int unsigned n, input logic burst);
		tick_t t;
		t.level = lvl;
		t.burst = burst;
		repeat (n) tick_q.push_back(t);
	endtask

	task automatic add_pulse(input int unsigned hi, input int unsigned lo, input logic burst);
		add_run(1'b1, hi, burst);
		add_run(1'b0, lo, burst);
	endtask

	function automatic int unsigned pick_width();
		if ($urandom_range(0, 9) < 9)
			return $urandom_range(1, 4);
		else
			return $urandom_range(5, 40);
	endfunction

	// mostly well-formed pulses, some noise bursts
	task automatic add_random_ticks();
		int unsigned added;
		int unsigned pulses;
		int unsigned hi;
		int unsigned lo;
		int unsigned n;
		added = 0;
		pulses = 0;
		while (added < PHASE_TICKS || pulses < PHASE_PULSES) begin
			if ($urandom_range(0, 9) < 2) begin
				n = $urandom_range(1, 4);
				add_run(1'($urandom_range(0, 1)), n, 1'b0);
				added = added + n;
			end else begin
				hi = pick_width();
				lo = pick_width();
				add_pulse(hi, lo, $urandom_range(0, 3) == 0);
				added = added + hi + lo;
				pulses = pulses + 1;
			end
		end
	endtask

	task automatic drain();
		while (tick_q.size() != 0 || sample_if.valid || meas_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [pdfc_pkg::ADDR_W-3:0] idx,
			input logic [pdfc_pkg::DATA_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		rate_write(idx, val);
	endtask

	task automatic apb_check_rate();
		logic [pdfc_pkg::DATA_W-1:0] got;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {pdfc_pkg::REG_TICK_RATE, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		got = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (got !== pdfc_pkg::DATA_W'(rate_q)) begin
			miss_cnt = miss_cnt + 1;
			if (miss_cnt <= 10)
				$display("rate readback: exp %0d got %0d", rate_q, got);
		end
	endtask

	logic [pdfc_pkg::DATA_W-1:0] rate_pick;

	initial begin
		reset_capture();
		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_check_rate();

		// directed pulses at the reset tick rate
		add_run(1'b0, 2, 1'b1);
		add_pulse(1, 1, 1'b1);
		add_pulse(1, 1, 1'b1);
		add_pulse(3, 5, 1'b0);
		add_pulse(2, 1, 1'b0);
		add_pulse(1, 1, 1'b1);
		drain();

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: rate_pick = 32'd1;
				1: rate_pick = 32'd100000000;
				2: rate_pick = 32'd0;
				3: rate_pick = 32'hFFFF_FFFF;
				default: rate_pick = $urandom_range(1, 100000000);
			endcase
			apb_write(pdfc_pkg::REG_TICK_RATE, rate_pick);
			if (p == 4)
				apb_write(REG_BEYOND, $urandom);
			apb_check_rate();
			if (p == 1) begin
				// receiver holds off while short pulses fill the queue
				@(posedge clk);
				squeeze_req <= 1'b1;
				repeat (2) @(posedge clk);
				for (int k = 0; k < SQUEEZE_PULSES; k++)
					add_pulse(1, 1, 1'b1);
			end
			add_random_ticks();
			drain();
		end

		if (miss_cnt == 0 && meas_q.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
